FILE: src/rsd_pkg.sv
// Shared types and constants for the restriction site digest block.
// No dependencies; imported by every module under src.
package rsd_pkg;

    localparam int LEN_W         = 5;   // wide enough for l5 + l3 and SITE_LEN
    localparam int RUN_W         = 4;
    localparam int PATTERN_BASES = 12;
    localparam int SITE_REGS     = 4;
    localparam int COUNT_W       = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int L5_LSB        = 24;
    localparam int L3_LSB        = 28;

    localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SITE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SITE_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SITE_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SITE_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SITE_FOUR  = 3'd4;

    typedef struct packed {
        logic [1:0] base;
        logic       unk;
        logic       cut;
        logic       last;
    } pay_t;

    typedef struct packed {
        pay_t pay;
        logic valid;
    } slot_t;

    typedef struct packed {
        logic [1:0] base;
        logic       unk;
        logic       frag_end;
        logic       seq_end;
        logic       run_end;
    } res_t;

endpackage

FILE: src/rsd_cell.sv
// One digest stage: a SITE_LEN deep window of bases with its site matcher.
// Depends on rsd_pkg.
module rsd_cell
    import rsd_pkg::*;
#(
    parameter int SITE_LEN = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        clr,
    input  logic [31:0] site,
    input  slot_t       in_slot,
    output slot_t       out_slot
);

    pay_t               win_reg [SITE_LEN];
    logic [SITE_LEN-1:0] vld_reg;
    logic [RUN_W-1:0]   run_reg;
    logic [RUN_W-1:0]   run_next;

    slot_t              tmp  [SITE_LEN+1];
    slot_t              mark [SITE_LEN+1];
    logic [3:0]         l5;
    logic [3:0]         l3;
    logic [LEN_W-1:0]   len;
    logic [RUN_W-1:0]   run_inc;
    logic               enabled;
    logic               match_ok;
    logic               hit;
    logic [15:0][1:0]   pat;
    logic [3:0]         pidx;

    assign l5  = site[L5_LSB +: 4];
    assign l3  = site[L3_LSB +: 4];
    assign len = {1'b0, l5} + {1'b0, l3};
    assign pat = {8'b0, site[23:0]};
    assign enabled = (len != '0) && (len <= LEN_W'(PATTERN_BASES))
                     && (len <= LEN_W'(SITE_LEN));
    assign run_inc = (run_reg == RUN_MAX) ? RUN_MAX : run_reg + 1'b1;

    always_comb
    begin
        tmp[0] = in_slot;
        for (int i = 0; i < SITE_LEN; i++)
        begin
            tmp[i+1].pay   = win_reg[i];
            tmp[i+1].valid = vld_reg[i];
        end
    end

    // newest base sits at tmp[0] and must equal the 3' end of the site
    always_comb
    begin
        match_ok = 1'b1;
        pidx     = '0;
        for (int i = 0; i < SITE_LEN; i++)
        begin
            if (LEN_W'(i) < len)
            begin
                pidx = 4'(len - LEN_W'(1) - LEN_W'(i));
                if (tmp[i].pay.unk || (tmp[i].pay.base != pat[pidx]))
                begin
                    match_ok = 1'b0;
                end
            end
        end
    end

    assign hit = in_slot.valid && enabled && ({1'b0, run_inc} >= len) && match_ok;

    // place the cut l3 bases back from the newest one
    always_comb
    begin
        for (int i = 0; i <= SITE_LEN; i++)
        begin
            mark[i] = tmp[i];
            if (hit && ({1'b0, l3} == LEN_W'(i)) && tmp[i].valid)
            begin
                mark[i].pay.cut = 1'b1;
            end
        end
    end

    assign out_slot = mark[SITE_LEN];

    always_comb
    begin
        if (!in_slot.valid || hit || in_slot.pay.cut)
        begin
            run_next = '0;
        end
        else
        begin
            run_next = run_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            run_reg <= '0;
        end
        else if (clr)
        begin
            vld_reg <= '0;
            run_reg <= '0;
        end
        else if (adv)
        begin
            for (int i = 0; i < SITE_LEN; i++)
            begin
                vld_reg[i] <= mark[i].valid;
            end
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < SITE_LEN; i++)
            begin
                win_reg[i] <= mark[i].pay;
            end
        end
    end

endmodule

FILE: src/rsd_obuf.sv
// Two-entry output buffer that decouples the stage chain from the receiver.
// Depends on rsd_pkg.
module rsd_obuf
    import rsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  res_t       push_data,
    output logic       space,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [1:0] out_base, [2] out_unknown, [3] fragment_end
    output logic       m_axis_tlast,   // sequence_end
    output logic       m_axis_tuser    // run_end
);

    res_t       e0_reg;
    res_t       e1_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign pop           = m_axis_tvalid && m_axis_tready;
    assign space         = (cnt_reg != 2'd2);
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {4'b0, e0_reg.frag_end, e0_reg.unk, e0_reg.base};
    assign m_axis_tlast  = e0_reg.seq_end;
    assign m_axis_tuser  = e0_reg.run_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (push && !pop)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e0_reg <= (push && cnt_reg == 2'd1) ? push_data : e1_reg;
            if (push)
            begin
                e1_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                e0_reg <= push_data;
            end
            else
            begin
                e1_reg <= push_data;
            end
        end
    end

endmodule

FILE: src/restriction_site_digest.sv
// Restriction site digest: cuts a base stream at up to four recognition sites.
// Depends on rsd_pkg, rsd_cell and rsd_obuf.
//
// Input stream s_axis carries one base per item (code and unknown flag in
// tdata, end of sequence in tlast). Output stream m_axis returns the same
// bases in order, tdata adding fragment_end, tlast marking the sequence's
// final base and tuser the last result caused by one input item.
// The cfg channel writes site_count (index 0) and the four site words
// (indexes 1 to 4); any write to those discards bases in flight.
// With N sites in use a base leaves the chain N*SITE_LEN items after it entered,
// then, as with none, passes through the output buffer register. Throughput is
// one base per cycle, but for flushes and a full output buffer: every stage
// shifts and matches in the same cycle. With sites in use, a base with tlast set
// starts a flush, one stage slot per cycle while the buffer has room, until that
// base leaves the chain; s_axis_tready stays low meanwhile. A stalled receiver
// fills the two-entry output buffer, then stops the stage chain and s_axis_tready;
// nothing is lost. Reset empties stages and buffer and zeroes the cfg registers.
module restriction_site_digest
    import rsd_pkg::*;
#(
    parameter int SITES    = 4,
    parameter int SITE_LEN = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [1:0] base_code, [2] is_unknown
    input  logic                 s_axis_tlast,   // seq_last
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [1:0] out_base, [2] out_unknown, [3] fragment_end
    output logic                 m_axis_tlast,   // sequence_end
    output logic                 m_axis_tuser,   // run_end
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int NCELL = (SITES < SITE_REGS) ? SITES : SITE_REGS;

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_FLUSH = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [31:0]        site_reg [SITE_REGS];
    logic [COUNT_W-1:0] active;
    logic               cfg_hit;
    logic               accept;
    logic               adv;
    logic               space;
    slot_t              in_slot;
    slot_t              chain [NCELL+1];
    slot_t              emit;
    res_t               res;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && cfg_ready && (cfg_index <= CFG_SITE_FOUR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < SITE_REGS; i++)
            begin
                site_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SITE_COUNT: count_reg   <= cfg_data[COUNT_W-1:0];
                CFG_SITE_ONE:   site_reg[0] <= cfg_data;
                CFG_SITE_TWO:   site_reg[1] <= cfg_data;
                CFG_SITE_THREE: site_reg[2] <= cfg_data;
                CFG_SITE_FOUR:  site_reg[3] <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign active = (count_reg > COUNT_W'(NCELL)) ? COUNT_W'(NCELL) : count_reg;

    assign s_axis_tready = (state_reg == ST_RUN) && space;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign adv           = accept || ((state_reg == ST_FLUSH) && space);

    always_comb
    begin
        in_slot.pay.base = s_axis_tdata[1:0];
        in_slot.pay.unk  = s_axis_tdata[2];
        in_slot.pay.cut  = 1'b0;
        in_slot.pay.last = s_axis_tlast;
        in_slot.valid    = 1'b1;
    end

    // feed bubbles while flushing
    assign chain[0] = (state_reg == ST_FLUSH) ? '0 : in_slot;

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        rsd_cell #(
            .SITE_LEN (SITE_LEN)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .clr      (cfg_hit),
            .site     (site_reg[k]),
            .in_slot  (chain[k]),
            .out_slot (chain[k+1])
        );
    end

    // tap the chain after the last stage in use
    always_comb
    begin
        emit = chain[0];
        for (int k = 1; k <= NCELL; k++)
        begin
            if (active == COUNT_W'(k))
            begin
                emit = chain[k];
            end
        end
    end

    always_comb
    begin
        res.base     = emit.pay.base;
        res.unk      = emit.pay.unk;
        res.frag_end = emit.pay.cut;
        res.seq_end  = emit.pay.last;
        res.run_end  = emit.pay.last || (accept && !s_axis_tlast);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (accept && s_axis_tlast && (active != '0))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (adv && emit.valid && emit.pay.last)
                begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
        if (cfg_hit)
        begin
            state_next = ST_RUN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    rsd_obuf u_obuf (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (adv && emit.valid),
        .push_data     (res),
        .space         (space),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_no_input_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> !s_axis_tready)
        else $error("input taken during flush");

    a_passthrough_next: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (active == '0)) |=> m_axis_tvalid)
        else $error("zero-site item not delivered next cycle");

    a_last_only_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && (active != '0) && emit.valid) |-> !emit.pay.last)
        else $error("sequence end left the chain outside a flush");
`endif

endmodule

FILE: test/tb.sv
// Testbench for restriction_site_digest: directed and random base streams, checked
// item by item against a behavioural model of the site matching chain held here.
// Depends on rsd_pkg and the RTL under src; reads no files.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsd_pkg::*;

    localparam int SITES      = 4;
    localparam int SITE_LEN   = 12;
    localparam int CLK_PERIOD = 10;
    localparam int DRAIN      = SITES * SITE_LEN + 8;
    localparam int LIMIT      = 400000;
    localparam int RAND_BASES = 75;

    // indexes past the register list; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [1:0] base;
        logic       unk;
        logic       cut;
        logic       valid;
    } lane_slot_t;

    typedef struct packed {
        logic [1:0] base;
        logic       unk;
        logic       frag_end;
        logic       seq_end;
        logic       run_end;
    } marked_base_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // [1:0] base_code, [2] is_unknown
    logic                 s_axis_tlast  = 1'b0; // seq_last
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;         // [1:0] out_base, [2] out_unknown, [3] fragment_end
    logic                 m_axis_tlast;         // sequence_end
    logic                 m_axis_tuser;         // run_end
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [31:0]          cfg_data      = '0;

    // model state
    lane_slot_t         stage_win [SITES][SITE_LEN];
    logic [RUN_W-1:0]   stage_run [SITES];
    logic [COUNT_W-1:0] shadow_count;
    logic [31:0]        site_word [SITE_REGS];
    marked_base_t       marked_q [$];

    string       site_text [SITE_REGS];
    string       alphabet   = "ACGTN";
    int unsigned gap_pct    = 0;
    int unsigned stall_pct  = 0;
    int          errors     = 0;
    int          checked    = 0;
    int          cuts_seen  = 0;
    int          sequences  = 0;
    int          bases_sent = 0;
    int          cycles     = 0;

    restriction_site_digest #(
        .SITES    (SITES),
        .SITE_LEN (SITE_LEN)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void clear_lanes();
        int k;
        int i;
        for (k = 0; k < SITES; k++)
        begin
            stage_run[k] = '0;
            for (i = 0; i < SITE_LEN; i++)
                stage_win[k][i] = '0;
        end
    endfunction

    // Shift one item into stage k, mark a cut on a hit, return the item leaving.
    function automatic lane_slot_t stage_shift(int k, lane_slot_t entry);
        lane_slot_t  tap [SITE_LEN+1];
        logic [31:0] word;
        int          l5;
        int          l3;
        int          span;
        int          run;
        int          i;
        bit          hit;
        tap[0] = entry;
        for (i = 0; i < SITE_LEN; i++)
            tap[i+1] = stage_win[k][i];
        word = site_word[k];
        l5   = word[L5_LSB +: 4];
        l3   = word[L3_LSB +: 4];
        span = l5 + l3;
        if (entry.valid)
        begin
            run = stage_run[k] + 1;
            if (run > RUN_MAX)
                run = RUN_MAX;
            if (span >= 1 && span <= PATTERN_BASES && span <= SITE_LEN && run >= span)
            begin
                hit = 1'b1;
                // oldest entry of the compared span faces the 5' end of the site
                for (i = 0; i < span; i++)
                    if (tap[i].unk || tap[i].base != word[2*(span-1-i) +: 2])
                        hit = 1'b0;
                if (hit)
                begin
                    if (tap[l3].valid)
                        tap[l3].cut = 1'b1;
                    run = 0;
                end
            end
            if (entry.cut)
                run = 0;
            stage_run[k] = RUN_W'(run);
        end
        else
            stage_run[k] = '0;
        for (i = 0; i < SITE_LEN; i++)
            stage_win[k][i] = tap[i];
        return tap[SITE_LEN];
    endfunction

    // Expected output items for one accepted base, flush included.
    function automatic void digest_step(logic [1:0] code, logic unknown, logic last);
        marked_base_t burst [SITES*SITE_LEN+1];
        lane_slot_t   slot;
        int           stages;
        int           n;
        int           t;
        int           k;
        stages = (shadow_count > SITES) ? SITES : int'(shadow_count);
        n      = 0;
        slot   = {code, unknown, 1'b0, 1'b1};
        for (t = 0; t <= (last ? stages * SITE_LEN : 0); t++)
        begin
            if (t > 0)
                slot = '0;
            for (k = 0; k < stages; k++)
                slot = stage_shift(k, slot);
            if (slot.valid)
            begin
                burst[n] = {slot.base, slot.unk, slot.cut, 2'b00};
                n++;
            end
        end
        if (last)
            clear_lanes();
        if (n > 0)
        begin
            burst[n-1].run_end = 1'b1;
            burst[n-1].seq_end = last;
        end
        for (t = 0; t < n; t++)
            marked_q = {marked_q, burst[t]};
    endfunction

    function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        if (idx == CFG_SITE_COUNT)
            shadow_count = value[COUNT_W-1:0];
        else if (idx >= CFG_SITE_ONE && idx <= CFG_SITE_FOUR)
            site_word[idx - CFG_SITE_ONE] = value;
        else
            return;
        clear_lanes();
    endfunction

    function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Check the output item first, then fold in this edge's writes and bases.
    always @(posedge clk)
    begin : monitor
        marked_base_t want;
        int           k;
        if (!rst_n)
        begin
            shadow_count = '0;
            for (k = 0; k < SITE_REGS; k++)
                site_word[k] = '0;
            clear_lanes();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (marked_q.size() == 0)
                begin
                    $error("unexpected item: tdata %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = marked_q.pop_front();
                    check_field("out_base", want.base, m_axis_tdata[1:0]);
                    check_field("out_unknown", 2'(want.unk), 2'(m_axis_tdata[2]));
                    check_field("fragment_end", 2'(want.frag_end), 2'(m_axis_tdata[3]));
                    check_field("sequence_end", 2'(want.seq_end), 2'(m_axis_tlast));
                    check_field("run_end", 2'(want.run_end), 2'(m_axis_tuser));
                    checked++;
                    if (want.frag_end)
                        cuts_seen++;
                end
            end
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                digest_step(s_axis_tdata[1:0], s_axis_tdata[2], s_axis_tlast);
        end
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("restriction_site_digest: mismatch");
            $finish;
        end
    end

    function automatic logic [1:0] code_of(byte c);
        case (c)
            "C":     return 2'd1;
            "G":     return 2'd2;
            "T":     return 2'd3;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [31:0] site_word_of(string text, int l5);
        logic [31:0] word;
        int          i;
        word = '0;
        for (i = 0; i < text.len(); i++)
            word[2*i +: 2] = code_of(text[i]);
        word[L5_LSB +: 4] = 4'(l5);
        word[L3_LSB +: 4] = 4'(text.len() - l5);
        return word;
    endfunction

    function automatic string random_text(int n);
        string text;
        int    i;
        int    r;
        text = "";
        for (i = 0; i < n; i++)
        begin
            r    = $urandom_range(3);
            text = {text, alphabet.substr(r, r)};
        end
        return text;
    endfunction

    task automatic send_base(logic [1:0] code, logic unknown, logic last);
        while ($urandom_range(99) < gap_pct)
            @(negedge clk);
        s_axis_tdata  = {5'd0, unknown, code};
        s_axis_tlast  = last;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        bases_sent++;
        if (last)
            sequences++;
    endtask

    // 'N' goes out as an unknown base with a random code.
    task automatic send_text(string text, bit close);
        int  i;
        bit  tail;
        for (i = 0; i < text.len(); i++)
        begin
            tail = close && (i == text.len() - 1);
            if (text[i] == "N")
                send_base(2'($urandom_range(3)), 1'b1, tail);
            else
                send_base(code_of(text[i]), 1'b0, tail);
        end
    endtask

    // Wait for every expected item, then long enough for held bases to settle.
    task automatic settle();
        while (marked_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        settle();
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_site(int k, string text, int l5);
        site_text[k] = text;
        set_reg(CFG_IDX_W'(CFG_SITE_ONE + k), site_word_of(text, l5));
    endtask

    task automatic load_raw_site(int k, logic [31:0] word);
        site_text[k] = "";
        set_reg(CFG_IDX_W'(CFG_SITE_ONE + k), word);
    endtask

    // Sequences mixing whole site copies, partial copies and noise.
    task automatic run_random(int unsigned gap, int unsigned stall);
        string text;
        int    quota;
        int    target;
        int    k;
        int    r;
        gap_pct   = gap;
        stall_pct = stall;
        quota     = bases_sent + RAND_BASES;
        while (bases_sent < quota)
        begin
            target = $urandom_range(36, 1);
            text   = "";
            while (text.len() < target)
            begin
                k = $urandom_range(SITE_REGS - 1);
                if ($urandom_range(9) < 4 && site_text[k].len() > 0)
                begin
                    if ($urandom_range(3) == 0)
                        text = {text, site_text[k].substr(0,
                                $urandom_range(site_text[k].len() - 1))};
                    else
                        text = {text, site_text[k]};
                end
                else
                begin
                    r    = ($urandom_range(19) == 0) ? 4 : $urandom_range(3);
                    text = {text, alphabet.substr(r, r)};
                end
            end
            send_text(text, 1'b1);
        end
        settle();
        gap_pct   = 0;
        stall_pct = 0;
    endtask

    task automatic test_passthrough();
        set_reg(CFG_SITE_COUNT, 32'd0);
        send_text("ACGTN", 1'b1);
    endtask

    task automatic test_single_cut();
        load_site(0, "GAATTC", 1);
        set_reg(CFG_SITE_COUNT, 32'd1);
        send_text("TGAATTCA", 1'b1);
    endtask

    // a cut in front of the first base of a sequence is dropped
    task automatic test_blunt_start();
        load_site(0, "GG", 0);
        send_text("GGAGG", 1'b1);
    endtask

    // cut after the final base merges with the sequence end
    task automatic test_end_cut();
        load_site(0, "TA", 2);
        send_text("CTA", 1'b1);
    endtask

    task automatic test_spare_index();
        send_text("ACG", 1'b0);
        set_reg(CFG_SPARE_LO, $urandom());
        set_reg(CFG_SPARE_HI, $urandom());
        send_text("TA", 1'b1);
    endtask

    // bases held in the stages are dropped by a register write
    task automatic test_write_discard();
        send_text("GTA", 1'b0);
        set_reg(CFG_SITE_COUNT, 32'd1);
        send_text("C", 1'b1);
    endtask

    task automatic test_random_short_sites();
        int k;
        int n;
        for (k = 0; k < SITE_REGS; k++)
        begin
            n = $urandom_range(4, 1);
            load_site(k, random_text(n), $urandom_range(n, 0));
        end
        set_reg(CFG_SITE_COUNT, 32'd3);
        run_random(0, 0);
    endtask

    task automatic test_random_blunt_sites();
        int n;
        load_site(0, random_text($urandom_range(3, 1)), 0);
        n = $urandom_range(4, 2);
        load_site(1, random_text(n), n);
        set_reg(CFG_SITE_COUNT, 32'd2);
        run_random(66, 0);
    endtask

    task automatic test_random_wide_sites();
        load_site(0, random_text(PATTERN_BASES), $urandom_range(PATTERN_BASES, 0));
        load_raw_site(1, {4'd7, 4'd6, 24'($urandom())});
        load_raw_site(2, {8'h00, 24'($urandom())});
        load_site(3, random_text(2), 1);
        set_reg(CFG_SITE_COUNT, 32'd7);
        run_random(0, 66);
    endtask

    task automatic test_random_mixed();
        int k;
        int n;
        for (k = 0; k < SITE_REGS - 1; k++)
        begin
            n = $urandom_range(5, 1);
            load_site(k, random_text(n), $urandom_range(n, 0));
        end
        load_raw_site(3, $urandom());
        set_reg(CFG_SITE_COUNT, 32'd4);
        run_random(7, 7);
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        test_passthrough();
        test_single_cut();
        test_blunt_start();
        test_end_cut();
        test_spare_index();
        test_write_discard();
        test_random_short_sites();
        test_random_blunt_sites();
        test_random_wide_sites();
        test_random_mixed();
        settle();
        $display("digest run: %0d bases in %0d sequences, %0d items checked, %0d cuts",
                 bases_sent, sequences, checked, cuts_seen);
        $display("site counts 0 to 7, blunt, end, wide and disabled sites, idle and stall mixes");
        if (errors == 0)
            $display("restriction_site_digest: match");
        else
            $display("restriction_site_digest: mismatch");
        $finish;
    end

endmodule

FILE: files.f
src/rsd_pkg.sv
src/rsd_cell.sv
src/rsd_obuf.sv
src/restriction_site_digest.sv
test/tb.sv
